FILE: rtl/lrfb_pkg.sv
// shared types and constants of the led ring frame buffer
package lrfb_pkg;

    localparam int OP_W      = 3;
    localparam int RING_W    = 3;
    localparam int LED_W     = 6;
    localparam int COLOR_W   = 8;
    localparam int PIXEL_W   = 3 * COLOR_W;
    localparam int SIZE_W    = 7;
    localparam int SUM_W     = 10;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 8;
    localparam int SIZE_REGS = 5;
    localparam int RING_LIMIT = 64;

    localparam logic [OP_W-1:0] OP_SET_PIX  = 3'd0;
    localparam logic [OP_W-1:0] OP_WR_PIX   = 3'd1;
    localparam logic [OP_W-1:0] OP_RD_PIX   = 3'd2;
    localparam logic [OP_W-1:0] OP_FILL_ALL = 3'd3;
    localparam logic [OP_W-1:0] OP_FILL_RNG = 3'd4;
    localparam logic [OP_W-1:0] OP_RD_RNG   = 3'd5;
    localparam logic [OP_W-1:0] OP_ROT_L    = 3'd6;
    localparam logic [OP_W-1:0] OP_ROT_R    = 3'd7;

    localparam logic [CFG_IDX_W-1:0] CFG_RING0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RING1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RING2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RING3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RING4 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RED   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE  = 3'd7;

    localparam logic [SIZE_W-1:0] SIZE_RESET [SIZE_REGS] =
        '{7'd24, 7'd16, 7'd12, 7'd8, 7'd1};
    localparam logic [COLOR_W-1:0] DRAW_RESET = 8'd32;

    localparam logic [1:0] KIND_HOLD  = 2'd0;
    localparam logic [1:0] KIND_FILL  = 2'd1;
    localparam logic [1:0] KIND_ROT_L = 2'd2;
    localparam logic [1:0] KIND_ROT_R = 2'd3;

    typedef struct packed {
        logic [1:0]         kind;
        logic [SUM_W-1:0]   lo;
        logic [SUM_W-1:0]   hi;
        logic [PIXEL_W-1:0] data;
    } cell_ctrl_t;

endpackage

FILE: rtl/lrfb_if.sv
// handshake channels of the led ring frame buffer
interface lrfb_cmd_if import lrfb_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [RING_W-1:0]  ring;
    logic [LED_W-1:0]   led;
    logic [COLOR_W-1:0] red_in;
    logic [COLOR_W-1:0] green_in;
    logic [COLOR_W-1:0] blue_in;
    modport source(output valid, op, ring, led, red_in, green_in, blue_in, input ready);
    modport sink(input valid, op, ring, led, red_in, green_in, blue_in, output ready);
endinterface

interface lrfb_rsp_if import lrfb_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [COLOR_W-1:0] red_out;
    logic [COLOR_W-1:0] green_out;
    logic [COLOR_W-1:0] blue_out;
    logic [LED_W-1:0]   led_index;
    logic               last;
    logic               error;
    modport source(output valid, red_out, green_out, blue_out, led_index, last, error,
                   input ready);
    modport sink(input valid, red_out, green_out, blue_out, led_index, last, error,
                 output ready);
endinterface

interface lrfb_cfg_if import lrfb_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

FILE: rtl/lrfb_cell.sv
// one pixel cell of the store chain
module lrfb_cell import lrfb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cell_ctrl_t         ctrl,
    input  logic [SUM_W-1:0]   my_pos,
    input  logic [PIXEL_W-1:0] left_pix,
    input  logic [PIXEL_W-1:0] right_pix,
    output logic [PIXEL_W-1:0] pix
);

    logic [PIXEL_W-1:0] pix_reg;
    logic [PIXEL_W-1:0] pix_next;
    logic               in_range;
    logic               is_first;
    logic               is_last;

    assign in_range = (my_pos >= ctrl.lo) && (my_pos < ctrl.hi);
    assign is_first = (my_pos == ctrl.lo);
    assign is_last  = ((my_pos + SUM_W'(1)) == ctrl.hi);

    always_comb
    begin
        pix_next = pix_reg;
        if (in_range)
        begin
            unique case (ctrl.kind)
                KIND_HOLD:  pix_next = pix_reg;
                KIND_FILL:  pix_next = ctrl.data;
                KIND_ROT_L: pix_next = is_last ? ctrl.data : left_pix;
                KIND_ROT_R: pix_next = is_first ? ctrl.data : right_pix;
                default:    pix_next = pix_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_reg <= '0;
        end
        else
        begin
            pix_reg <= pix_next;
        end
    end

    assign pix = pix_reg;

endmodule

FILE: rtl/led_ring_frame_buffer.sv
// top level of the led ring frame buffer: command sequencer and cell chain
//
//  channel  dir   word                                          done when
//  cmd      in    op, ring, led, red_in, green_in, blue_in      valid && ready
//  rsp      out   red_out, green_out, blue_out, led_index,      valid && ready
//                 last, error
//  cfg      in    index, data                                   valid && ready
//
// one command at a time: the sequencer runs idle, calc and decide, then by op
// the read, error or rotate capture and shift states; all reads use the one read mux
// the cells shift a whole ring at once, each taking its neighbor's pixel
// the store is cleared by reset, so commands are taken right after reset
// a stalled result holds the sequencer in the read or error state; cfg is always ready
module led_ring_frame_buffer import lrfb_pkg::*;
#(
    parameter int MAX_LEDS   = 64,
    parameter int RING_COUNT = 5
)
(
    input  logic       clk,
    input  logic       rst_n,
    lrfb_cmd_if.sink   cmd,
    lrfb_rsp_if.source rsp,
    lrfb_cfg_if.sink   cfg
);

    localparam int AW = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_CALC    = 3'd1;
    localparam logic [2:0] ST_DECIDE  = 3'd2;
    localparam logic [2:0] ST_READ    = 3'd3;
    localparam logic [2:0] ST_ERR     = 3'd4;
    localparam logic [2:0] ST_ROT_CAP = 3'd5;
    localparam logic [2:0] ST_ROT_SH  = 3'd6;

    logic [SIZE_W-1:0]  ring_size_reg [SIZE_REGS];
    logic [COLOR_W-1:0] draw_red_reg;
    logic [COLOR_W-1:0] draw_green_reg;
    logic [COLOR_W-1:0] draw_blue_reg;

    logic [2:0]         state_reg, state_next;
    logic [OP_W-1:0]    op_reg, op_next;
    logic [RING_W-1:0]  ring_reg, ring_next;
    logic [LED_W-1:0]   led_reg, led_next;
    logic [PIXEL_W-1:0] px_in_reg, px_in_next;
    logic [SUM_W-1:0]   base_reg, base_next;
    logic [SUM_W-1:0]   total_reg, total_next;
    logic [SIZE_W-1:0]  sz_reg, sz_next;
    logic [LED_W-1:0]   cnt_reg, cnt_next;
    logic [PIXEL_W-1:0] carry_reg, carry_next;
    logic [LED_W-1:0]   err_led_reg, err_led_next;

    logic               rsp_valid_reg, rsp_valid_next;
    logic [PIXEL_W-1:0] rsp_pix_reg, rsp_pix_next;
    logic [LED_W-1:0]   rsp_led_reg, rsp_led_next;
    logic               rsp_last_reg, rsp_last_next;
    logic               rsp_err_reg, rsp_err_next;

    logic [SUM_W-1:0]   base_calc;
    logic [SUM_W-1:0]   total_calc;
    logic [SIZE_W-1:0]  sz_calc;
    logic [SUM_W-1:0]   span_end;
    logic [SUM_W-1:0]   rd_pos;
    logic [PIXEL_W-1:0] rd_pix;
    logic [PIXEL_W-1:0] draw_pix;
    logic               slot_free;
    logic               cmd_err;
    logic               read_last;
    cell_ctrl_t         ctrl;
    logic [PIXEL_W-1:0] cell_pix [MAX_LEDS];

    assign draw_pix  = {draw_green_reg, draw_red_reg, draw_blue_reg};
    assign slot_free = !rsp_valid_reg || rsp.ready;
    assign span_end  = base_reg + SUM_W'(sz_reg);
    assign cmd.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SIZE_REGS; i++)
            begin
                ring_size_reg[i] <= SIZE_RESET[i];
            end
            draw_red_reg   <= DRAW_RESET;
            draw_green_reg <= DRAW_RESET;
            draw_blue_reg  <= DRAW_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index) inside
                CFG_RING0, CFG_RING1, CFG_RING2, CFG_RING3, CFG_RING4:
                    ring_size_reg[cfg.index] <= cfg.data[SIZE_W-1:0];
                CFG_RED:   draw_red_reg   <= cfg.data;
                CFG_GREEN: draw_green_reg <= cfg.data;
                CFG_BLUE:  draw_blue_reg  <= cfg.data;
                default:   draw_blue_reg  <= draw_blue_reg;
            endcase
        end
    end

    // ring base, ring size and total span
    always_comb
    begin
        base_calc  = '0;
        total_calc = '0;
        for (int i = 0; i < SIZE_REGS; i++)
        begin
            if (RING_W'(i) < ring_reg)
            begin
                base_calc = base_calc + SUM_W'(ring_size_reg[i]);
            end
            if (i < RING_COUNT)
            begin
                total_calc = total_calc + SUM_W'(ring_size_reg[i]);
            end
        end
        sz_calc = (ring_reg < RING_W'(SIZE_REGS)) ? ring_size_reg[ring_reg] : '0;
    end

    always_comb
    begin
        if (op_reg == OP_FILL_ALL)
        begin
            cmd_err = (total_reg > SUM_W'(MAX_LEDS));
        end
        else
        begin
            cmd_err = ({1'b0, ring_reg} >= (RING_W + 1)'(RING_COUNT))
                   || (sz_reg > SIZE_W'(RING_LIMIT))
                   || (span_end > SUM_W'(MAX_LEDS))
                   || ((op_reg <= OP_RD_PIX) && ({1'b0, led_reg} >= sz_reg));
        end
    end

    // single read port over the chain
    always_comb
    begin
        if (state_reg == ST_ROT_CAP && op_reg == OP_ROT_R)
        begin
            rd_pos = span_end - SUM_W'(1);
        end
        else
        begin
            rd_pos = base_reg + SUM_W'(cnt_reg);
        end
    end
    assign rd_pix    = cell_pix[rd_pos[AW-1:0]];
    assign read_last = (op_reg == OP_RD_PIX)
                    || (({1'b0, cnt_reg} + SIZE_W'(1)) == sz_reg);

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        ring_next      = ring_reg;
        led_next       = led_reg;
        px_in_next     = px_in_reg;
        base_next      = base_reg;
        total_next     = total_reg;
        sz_next        = sz_reg;
        cnt_next       = cnt_reg;
        carry_next     = carry_reg;
        err_led_next   = err_led_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        rsp_pix_next   = rsp_pix_reg;
        rsp_led_next   = rsp_led_reg;
        rsp_last_next  = rsp_last_reg;
        rsp_err_next   = rsp_err_reg;
        ctrl.kind      = KIND_HOLD;
        ctrl.lo        = '0;
        ctrl.hi        = '0;
        ctrl.data      = draw_pix;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    op_next    = cmd.op;
                    ring_next  = cmd.ring;
                    led_next   = cmd.led;
                    px_in_next = {cmd.green_in, cmd.red_in, cmd.blue_in};
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                base_next  = base_calc;
                total_next = total_calc;
                sz_next    = sz_calc;
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                err_led_next = (op_reg <= OP_RD_PIX) ? led_reg : '0;
                cnt_next     = (op_reg == OP_RD_PIX) ? led_reg : '0;
                state_next   = ST_IDLE;
                if (cmd_err)
                begin
                    state_next = ST_ERR;
                end
                else
                begin
                    case (op_reg)
                        OP_SET_PIX, OP_WR_PIX:
                        begin
                            ctrl.kind = KIND_FILL;
                            ctrl.lo   = base_reg + SUM_W'(led_reg);
                            ctrl.hi   = base_reg + SUM_W'(led_reg) + SUM_W'(1);
                            ctrl.data = (op_reg == OP_SET_PIX) ? draw_pix : px_in_reg;
                        end
                        OP_RD_PIX:
                        begin
                            state_next = ST_READ;
                        end
                        OP_FILL_ALL:
                        begin
                            ctrl.kind = KIND_FILL;
                            ctrl.lo   = '0;
                            ctrl.hi   = total_reg;
                        end
                        OP_FILL_RNG:
                        begin
                            ctrl.kind = KIND_FILL;
                            ctrl.lo   = base_reg;
                            ctrl.hi   = span_end;
                        end
                        OP_RD_RNG:
                        begin
                            if (sz_reg != '0)
                            begin
                                state_next = ST_READ;
                            end
                        end
                        default:
                        begin
                            if (sz_reg >= SIZE_W'(2))
                            begin
                                state_next = ST_ROT_CAP;
                            end
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                if (slot_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_pix_next   = rd_pix;
                    rsp_led_next   = cnt_reg;
                    rsp_last_next  = read_last;
                    rsp_err_next   = 1'b0;
                    if (read_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + LED_W'(1);
                    end
                end
            end
            ST_ERR:
            begin
                if (slot_free)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_pix_next   = '0;
                    rsp_led_next   = err_led_reg;
                    rsp_last_next  = 1'b1;
                    rsp_err_next   = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_ROT_CAP:
            begin
                carry_next = rd_pix;
                state_next = ST_ROT_SH;
            end
            ST_ROT_SH:
            begin
                ctrl.kind  = (op_reg == OP_ROT_L) ? KIND_ROT_L : KIND_ROT_R;
                ctrl.lo    = base_reg;
                ctrl.hi    = span_end;
                ctrl.data  = carry_reg;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
            carry_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            carry_reg     <= carry_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        ring_reg     <= ring_next;
        led_reg      <= led_next;
        px_in_reg    <= px_in_next;
        base_reg     <= base_next;
        total_reg    <= total_next;
        sz_reg       <= sz_next;
        cnt_reg      <= cnt_next;
        err_led_reg  <= err_led_next;
        rsp_pix_reg  <= rsp_pix_next;
        rsp_led_reg  <= rsp_led_next;
        rsp_last_reg <= rsp_last_next;
        rsp_err_reg  <= rsp_err_next;
    end

    // cell chain
    for (genvar g = 0; g < MAX_LEDS; g++)
    begin : g_cell
        logic [PIXEL_W-1:0] left_pix;
        logic [PIXEL_W-1:0] right_pix;

        if (g == MAX_LEDS - 1)
        begin : g_end
            assign left_pix = '0;
        end
        else
        begin : g_mid
            assign left_pix = cell_pix[g + 1];
        end

        if (g == 0)
        begin : g_first
            assign right_pix = '0;
        end
        else
        begin : g_rest
            assign right_pix = cell_pix[g - 1];
        end

        lrfb_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .my_pos    (SUM_W'(g)),
            .left_pix  (left_pix),
            .right_pix (right_pix),
            .pix       (cell_pix[g])
        );
    end

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.green_out = rsp_pix_reg[PIXEL_W-1 -: COLOR_W];
    assign rsp.red_out   = rsp_pix_reg[2*COLOR_W-1 -: COLOR_W];
    assign rsp.blue_out  = rsp_pix_reg[COLOR_W-1:0];
    assign rsp.led_index = rsp_led_reg;
    assign rsp.last      = rsp_last_reg;
    assign rsp.error     = rsp_err_reg;

endmodule
